>>> design/complex_magnitude_isqrt_macros.svh
// Assertion macros used by the complex magnitude top module.
// Each macro samples on clk; CMI_ASSERT is disabled while arst_n is low, CMI_ASSERT_ALWAYS is not.
`ifndef COMPLEX_MAGNITUDE_ISQRT_MACROS_SVH
`define COMPLEX_MAGNITUDE_ISQRT_MACROS_SVH

`define CMI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define CMI_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/cmi_pkg.sv
// Package for the complex magnitude block: widths and the root cell payload type.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package cmi_pkg;

	localparam int PartBits   = 32;
	localparam int EnergyBits = 64;
	localparam int RootBits   = 32;
	localparam int RemBits    = RootBits + 2;

	localparam logic [RootBits-1:0] MagMax = 32'd3037000499;

	typedef struct packed {
		logic [EnergyBits-1:0] num;
		logic [RemBits-1:0]    rem;
		logic [RootBits-1:0]   root;
	} cmi_root_t;

endpackage

>>> design/complex_magnitude_isqrt.sv
// Complex magnitude: floor of the square root of re^2 + im^2 for signed 32-bit parts.
// An accepted item passes two energy stages, then 32 root cells, on its way to a result.
// Throughput is one item per cycle unless stalled; each of 32 root cells settles one root bit.
// Every stage holds its item under stall and takes a new one as soon as it empties.
// Reset clears the stage valid flags only; the data registers are not reset.
// Depends on cmi_pkg, cmi_energy, cmi_root_cell and complex_magnitude_isqrt_macros.svh.
`timescale 1ns / 1ps
`include "complex_magnitude_isqrt_macros.svh"

module complex_magnitude_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [cmi_pkg::PartBits-1:0] real_part,
	input  logic signed [cmi_pkg::PartBits-1:0] imag_part,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic        [cmi_pkg::RootBits-1:0] magnitude
);
	import cmi_pkg::*;

	logic [EnergyBits-1:0] energy;
	logic                  energy_valid;
	logic                  energy_stall;
	logic                  chain_valid [RootBits+1];
	logic                  chain_stall [RootBits+1];
	cmi_root_t             chain_data  [RootBits+1];
	logic [RemBits-1:0]    final_rem;

	cmi_energy u_energy (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (sample_valid),
		.up_stall  (sample_stall),
		.real_part (real_part),
		.imag_part (imag_part),
		.dn_valid  (energy_valid),
		.dn_stall  (energy_stall),
		.energy    (energy)
	);

	assign chain_valid[0]     = energy_valid;
	assign energy_stall       = chain_stall[0];
	assign chain_data[0].num  = energy;
	assign chain_data[0].rem  = '0;
	assign chain_data[0].root = '0;

	for (genvar i = 0; i < RootBits; i++) begin : g_cell
		cmi_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_stall (chain_stall[i]),
			.up_data  (chain_data[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_stall (chain_stall[i+1]),
			.dn_data  (chain_data[i+1])
		);
	end

	assign chain_stall[RootBits] = result_stall;
	assign result_valid          = chain_valid[RootBits];
	assign magnitude             = chain_data[RootBits].root;
	assign final_rem             = chain_data[RootBits].rem;

	// Floor root leaves a remainder no greater than twice the root.
	`CMI_ASSERT(a_mag_range, result_valid |-> (magnitude <= MagMax), "magnitude too large")
	`CMI_ASSERT(a_rem_floor, result_valid |-> (final_rem <= {1'b0, magnitude, 1'b0}), "root too small")
	`CMI_ASSERT(a_empty_ready, !result_valid |-> !sample_stall, "input stalled while output empty")
endmodule

>>> design/cmi_energy.sv
// Energy front end: absolute values and squares in the first stage, their sum in the second.
// Depends on cmi_pkg.
`timescale 1ns / 1ps

module cmi_energy (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 up_valid,
	output logic                                 up_stall,
	input  logic signed [cmi_pkg::PartBits-1:0]  real_part,
	input  logic signed [cmi_pkg::PartBits-1:0]  imag_part,
	output logic                                 dn_valid,
	input  logic                                 dn_stall,
	output logic        [cmi_pkg::EnergyBits-1:0] energy
);
	import cmi_pkg::*;

	logic [PartBits-1:0]   re_abs;
	logic [PartBits-1:0]   im_abs;
	logic [EnergyBits-1:0] re_sq;
	logic [EnergyBits-1:0] im_sq;
	logic [EnergyBits-1:0] re_sq_s1;
	logic [EnergyBits-1:0] im_sq_s1;
	logic [EnergyBits-1:0] energy_s2;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  ready_s1;
	logic                  ready_s2;

	// The most negative part negates to itself, which read as unsigned is 2^31.
	assign re_abs = real_part[PartBits-1] ? (~$unsigned(real_part) + 32'd1) : $unsigned(real_part);
	assign im_abs = imag_part[PartBits-1] ? (~$unsigned(imag_part) + 32'd1) : $unsigned(imag_part);
	assign re_sq  = {32'd0, re_abs} * {32'd0, re_abs};
	assign im_sq  = {32'd0, im_abs} * {32'd0, im_abs};

	assign ready_s2 = !valid_s2 || !dn_stall;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= up_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			re_sq_s1 <= re_sq;
			im_sq_s1 <= im_sq;
		end
		if (ready_s2 && valid_s1) begin
			energy_s2 <= re_sq_s1 + im_sq_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign energy   = energy_s2;

endmodule

>>> design/cmi_root_cell.sv
// One cell of the square root chain: decides one root bit from the next two energy bits.
// Depends on cmi_pkg.
`timescale 1ns / 1ps

module cmi_root_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_stall,
	input  cmi_pkg::cmi_root_t up_data,
	output logic               dn_valid,
	input  logic               dn_stall,
	output cmi_pkg::cmi_root_t dn_data
);
	import cmi_pkg::*;

	logic [RemBits-1:0] rem_shift;
	logic [RemBits-1:0] trial;
	logic               take;
	cmi_root_t          next_data;
	cmi_root_t          data_q;
	logic               valid_q;
	logic               ready;

	assign rem_shift = {up_data.rem[RootBits-1:0], up_data.num[EnergyBits-1 -: 2]};
	assign trial     = {up_data.root, 2'b01};
	assign take      = rem_shift >= trial;

	always_comb begin
		next_data.num  = {up_data.num[EnergyBits-3:0], 2'b00};
		next_data.rem  = take ? (rem_shift - trial) : rem_shift;
		next_data.root = {up_data.root[RootBits-2:0], take};
	end

	assign ready    = !valid_q || !dn_stall;
	assign up_stall = !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && up_valid) begin
			data_q <= next_data;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

>>> test/complex_magnitude_isqrt_tb.sv
// Self-checking testbench for complex_magnitude_isqrt: directed table samples, then random samples
// with and without sender gaps and receiver stalls, each checked against the table or a local model.
// Depends on cmi_pkg and the complex_magnitude_isqrt RTL.
`timescale 1ns / 1ps

module complex_magnitude_isqrt_tb;

	import cmi_pkg::*;

	typedef struct packed {
		logic signed [PartBits-1:0] re;
		logic signed [PartBits-1:0] im;
		logic                       known;
		logic [RootBits-1:0]        mag;
	} sample_row_t;

	localparam int RowCount = 16;
	localparam int RandomPerPhase = 600;

	localparam sample_row_t DirectedRows [RowCount] = '{
		'{32'sd0,          32'sd0,          1'b1, 32'd0},
		'{32'sd1,          32'sd0,          1'b1, 32'd1},
		'{32'sd0,          -32'sd1,         1'b1, 32'd1},
		'{32'sd1,          32'sd1,          1'b1, 32'd1},
		'{32'sd2,          32'sd2,          1'b1, 32'd2},
		'{32'sd3,          32'sd4,          1'b1, 32'd5},
		'{-32'sd3,         -32'sd4,         1'b1, 32'd5},
		'{32'sh7fff_ffff,  32'sd0,          1'b1, 32'd2147483647},
		'{32'sh8000_0000,  32'sd0,          1'b1, 32'd2147483648},
		'{32'sd0,          32'sh8000_0000,  1'b1, 32'd2147483648},
		'{32'sh8000_0000,  32'sh8000_0000,  1'b1, MagMax},
		'{32'sh7fff_ffff,  32'sh7fff_ffff,  1'b0, 32'd0},
		'{32'sh8000_0000,  32'sh7fff_ffff,  1'b0, 32'd0},
		'{32'sh7fff_ffff,  32'sh8000_0001,  1'b0, 32'd0},
		'{32'sd65535,      32'sd65536,      1'b0, 32'd0},
		'{-32'sd46341,     32'sd46340,      1'b0, 32'd0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [PartBits-1:0] real_part = '0;
	logic signed [PartBits-1:0] imag_part = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic [RootBits-1:0]        magnitude;

	logic [RootBits-1:0] pending_magnitudes [$];
	int                  mismatch_count = 0;
	int                  send_idle_pct = 28;
	int                  recv_stall_pct = 51;

	complex_magnitude_isqrt uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.real_part    (real_part),
		.imag_part    (imag_part),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.magnitude    (magnitude)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("complex_magnitude_isqrt verification failed");
		$finish;
	end

	function automatic logic [RootBits-1:0] floor_magnitude(logic signed [PartBits-1:0] re,
			logic signed [PartBits-1:0] im);
		logic signed [EnergyBits-1:0] re_wide;
		logic signed [EnergyBits-1:0] im_wide;
		logic [EnergyBits-1:0]        re_abs;
		logic [EnergyBits-1:0]        im_abs;
		logic [EnergyBits-1:0]        energy;
		logic [EnergyBits-1:0]        trial;
		logic [RootBits-1:0]          root;
		re_wide = re;
		im_wide = im;
		re_abs = (re_wide < 0) ? -re_wide : re_wide;
		im_abs = (im_wide < 0) ? -im_wide : im_wide;
		energy = re_abs * re_abs + im_abs * im_abs;
		root = '0;
		for (int b = RootBits - 1; b >= 0; b--) begin
			trial = {32'd0, root | (32'd1 << b)};
			if (trial * trial <= energy) begin
				root = root | (32'd1 << b);
			end
		end
		return root;
	endfunction

	task automatic note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	task automatic send_sample(logic signed [PartBits-1:0] re, logic signed [PartBits-1:0] im,
			logic known, logic [RootBits-1:0] mag);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		real_part <= re;
		imag_part <= im;
		@(posedge clk);
		while (sample_stall) begin
			@(posedge clk);
		end
		pending_magnitudes.push_back(known ? mag : floor_magnitude(re, im));
	endtask

	function automatic logic signed [PartBits-1:0] random_part();
		logic signed [PartBits-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $signed($urandom_range(0, 128)) - 32'sd64;
			2: v = $urandom_range(0, 1) ? (32'sh8000_0000 + $urandom_range(0, 3))
					: (32'sh7fff_ffff - $urandom_range(0, 3));
			3: v = $signed($urandom) >>> $urandom_range(0, 31);
			4: v = 32'sd0;
			default: v = $urandom_range(0, 1) ? $signed($urandom_range(0, 65535))
					: -$signed($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	task automatic send_random();
		logic signed [PartBits-1:0] re;
		logic signed [PartBits-1:0] im;
		int                         k;
		if ($urandom_range(0, 7) == 0) begin
			// Pythagorean pairs land exactly on a whole root.
			k = $urandom_range(1, 400000000);
			re = 3 * k;
			im = 4 * k;
			if ($urandom_range(0, 1)) re = -re;
			if ($urandom_range(0, 1)) im = -im;
		end else begin
			re = random_part();
			im = random_part();
		end
		send_sample(re, im, 1'b0, '0);
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_magnitudes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		logic [RootBits-1:0] want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_magnitudes.size() == 0) begin
				note_failure($sformatf("unexpected result: magnitude %0d", magnitude));
			end else begin
				want = pending_magnitudes.pop_front();
				if (magnitude !== want) begin
					note_failure($sformatf("magnitude mismatch: expected %0d, got %0d",
						want, magnitude));
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < RowCount; i++) begin
			send_sample(DirectedRows[i].re, DirectedRows[i].im, DirectedRows[i].known,
				DirectedRows[i].mag);
		end
		for (int i = 0; i < RandomPerPhase; i++) begin
			if (i == RandomPerPhase / 2) begin
				drain_results();
			end
			send_random();
		end
		drain_results();

		send_idle_pct = 51;
		recv_stall_pct = 28;
		for (int i = 0; i < RandomPerPhase; i++) begin
			send_random();
		end
		drain_results();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < RandomPerPhase; i++) begin
			send_random();
		end
		drain_results();

		repeat (40) @(posedge clk);
		if (pending_magnitudes.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", pending_magnitudes.size()));
		end
		if (mismatch_count == 0) begin
			$display("complex_magnitude_isqrt verification clean");
		end else begin
			$display("complex_magnitude_isqrt verification failed");
		end
		$finish;
	end

endmodule

>>> complex_magnitude_isqrt.f
+incdir+design
design/cmi_pkg.sv
design/cmi_energy.sv
design/cmi_root_cell.sv
design/complex_magnitude_isqrt.sv
test/complex_magnitude_isqrt_tb.sv
